// ===== src/rtpidr_pkg.sv =====
// Shared types and constants for the RTP H.264 IDR packet dropper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rtpidr_pkg;

  // Width of the internal IDR / non-IDR counters; totals show the low 32 bits.
  localparam int COUNT_BITS = 32;
  localparam int TOTAL_BITS = 32;

  // Frame-verdict queue between parser and counter stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEST_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_UDP_PORT = 2'd1;
  localparam logic [1:0] CFG_DROP_PERIOD = 2'd2;

  // Configuration reset values.
  localparam logic [31:0] DEST_ADDRESS_RESET = 32'h0A00_0002;
  localparam logic [15:0] UDP_PORT_RESET = 16'd5004;
  localparam logic [7:0] DROP_PERIOD_RESET = 8'd10;

  typedef enum logic [1:0] {
    CLASS_NONE    = 2'd0,
    CLASS_IDR     = 2'd1,
    CLASS_NON_IDR = 2'd2
  } frame_class_t;

  typedef struct packed {
    logic [31:0] dest_address;
    logic [15:0] udp_port;
    logic [7:0]  drop_period;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/rtpidr_parser.sv =====
// Front end: walks the frame byte by byte, checks the header fields and
// classifies the frame on its last byte. Depends on rtpidr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpidr_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rtpidr_pkg::cfg_t     cfg,
  input  wire logic                 byte_accept,
  input  wire logic [7:0]           packet_byte,
  input  wire logic                 end_of_packet,
  output rtpidr_pkg::frame_class_t  verdict_class,
  output logic                      verdict_push
);
  import rtpidr_pkg::*;

  localparam logic [6:0] POS_MAX = 7'd127;
  localparam logic [6:0] POS_TYPE_HI = 7'd12;
  localparam logic [6:0] POS_TYPE_LO = 7'd13;
  localparam logic [6:0] POS_IHL = 7'd14;
  localparam logic [6:0] POS_PROTO = 7'd23;
  localparam logic [6:0] POS_DADDR_FIRST = 7'd30;
  localparam logic [6:0] POS_DADDR_LAST = 7'd33;
  localparam logic [6:0] IP_START = 7'd14;
  localparam logic [6:0] PAYLOAD_2ND_OFS = 7'd35;  // IP start + UDP 8 + RTP 12 + 1
  localparam logic [3:0] IHL_MIN = 4'd5;
  localparam logic [7:0] ETYPE_HI = 8'h08;
  localparam logic [7:0] ETYPE_LO = 8'h00;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [1:0] RTP_VERSION = 2'd2;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_FU_A = 5'd28;

  logic [6:0] pos_r, pos_nxt;
  logic [3:0] hw_r, hw_nxt;
  logic       match_r, match_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;

  logic [6:0] udp_pos;
  logic [6:0] need_pos;
  logic       test;
  logic [7:0] want;
  logic [4:0] nal;
  logic       counted;

  always_comb begin
    hw_nxt = hw_r;
    match_nxt = match_r;
    first_nxt = first_r;
    second_nxt = second_r;
    test = 1'b1;
    want = 8'h00;
    udp_pos = IP_START + {1'b0, hw_r, 2'b00};

    if (pos_r == POS_TYPE_HI) begin
      want = ETYPE_HI;
    end else if (pos_r == POS_TYPE_LO) begin
      want = ETYPE_LO;
    end else if (pos_r == POS_IHL) begin
      hw_nxt = packet_byte[3:0];
      if (packet_byte[3:0] < IHL_MIN) match_nxt = 1'b0;
      test = 1'b0;
    end else if (pos_r == POS_PROTO) begin
      want = PROTO_UDP;
    end else if (pos_r >= POS_DADDR_FIRST && pos_r <= POS_DADDR_LAST) begin
      // address goes out most significant byte first
      case (pos_r[1:0])
        2'b10:   want = cfg.dest_address[31:24];
        2'b11:   want = cfg.dest_address[23:16];
        2'b00:   want = cfg.dest_address[15:8];
        default: want = cfg.dest_address[7:0];
      endcase
    end else if (pos_r == udp_pos + 7'd2) begin
      want = cfg.udp_port[15:8];
    end else if (pos_r == udp_pos + 7'd3) begin
      want = cfg.udp_port[7:0];
    end else if (pos_r == udp_pos + 7'd8) begin
      if (packet_byte[7:6] != RTP_VERSION) match_nxt = 1'b0;
      test = 1'b0;
    end else if (pos_r == udp_pos + 7'd20) begin
      first_nxt = packet_byte;
      test = 1'b0;
    end else if (pos_r == udp_pos + 7'd21) begin
      second_nxt = packet_byte;
      test = 1'b0;
    end else begin
      test = 1'b0;
    end

    if (test && packet_byte != want) match_nxt = 1'b0;

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 7'd1;

    // verdict uses the state including this byte
    need_pos = PAYLOAD_2ND_OFS + {1'b0, hw_nxt, 2'b00};
    counted = match_nxt && (hw_nxt >= IHL_MIN) && (pos_r >= need_pos);
    nal = first_nxt[4:0];
    if (nal == NAL_FU_A) nal = second_nxt[4:0];

    verdict_class = CLASS_NONE;
    if (counted && nal == NAL_IDR) verdict_class = CLASS_IDR;
    else if (counted && nal == NAL_NON_IDR) verdict_class = CLASS_NON_IDR;

    verdict_push = byte_accept && end_of_packet;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hw_r <= '0;
      match_r <= 1'b1;
      first_r <= '0;
      second_r <= '0;
    end else if (byte_accept) begin
      if (end_of_packet) begin
        pos_r <= '0;
        hw_r <= '0;
        match_r <= 1'b1;
        first_r <= '0;
        second_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        hw_r <= hw_nxt;
        match_r <= match_nxt;
        first_r <= first_nxt;
        second_r <= second_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rtpidr_queue.sv =====
// Short verdict queue between the parser and the counter stage.
// Depends on rtpidr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpidr_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire rtpidr_pkg::frame_class_t push_class,
  output logic                          full,
  input  wire logic                     pop,
  output rtpidr_pkg::frame_class_t      pop_class,
  output logic                          empty
);
  import rtpidr_pkg::*;

  frame_class_t entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_BITS:0]   count_r, count_nxt;
  logic                      do_push, do_pop;

  assign full = (count_r == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_class = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_class;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/rtpidr_counter.sv =====
// Back end: counts IDR / non-IDR frames, runs the drop phase and holds the
// result in an output register. Depends on rtpidr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpidr_counter (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [7:0]               drop_period,
  input  wire logic                     queue_empty,
  input  wire rtpidr_pkg::frame_class_t queue_class,
  output logic                          queue_pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_drop,
  output rtpidr_pkg::frame_class_t      out_frame_class,
  output logic [rtpidr_pkg::TOTAL_BITS-1:0] out_idr_total,
  output logic [rtpidr_pkg::TOTAL_BITS-1:0] out_non_idr_total
);
  import rtpidr_pkg::*;

  logic [COUNT_BITS-1:0] idr_count_r, non_idr_count_r;
  logic [7:0]            phase_r, phase_inc;
  logic                  valid_r, drop_r, drop_nxt;
  frame_class_t          class_r;

  assign queue_pop = !queue_empty && (!valid_r || !out_stall);
  assign phase_inc = phase_r + 8'd1;
  assign drop_nxt = (queue_class == CLASS_IDR) && (phase_inc >= drop_period);

  assign out_valid = valid_r;
  assign out_drop = drop_r;
  assign out_frame_class = class_r;
  assign out_idr_total = TOTAL_BITS'(idr_count_r);
  assign out_non_idr_total = TOTAL_BITS'(non_idr_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idr_count_r <= '0;
      non_idr_count_r <= '0;
      phase_r <= '0;
    end else begin
      if (queue_pop) begin
        valid_r <= 1'b1;
        if (queue_class == CLASS_IDR) begin
          idr_count_r <= idr_count_r + 1'b1;
          phase_r <= drop_nxt ? 8'd0 : phase_inc;
        end else if (queue_class == CLASS_NON_IDR) begin
          non_idr_count_r <= non_idr_count_r + 1'b1;
        end
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (queue_pop) begin
      drop_r <= drop_nxt;
      class_r <= queue_class;
    end
  end

endmodule

`default_nettype wire

// ===== src/rtp_h264_idr_packet_dropper.sv =====
// RTP H.264 IDR packet dropper, top level: configuration registers, parser,
// verdict queue and counter stage. Depends on rtpidr_pkg and its submodules.
//
// Usage:
//   Input channel (in_*): one Ethernet frame byte per transaction, starting
//   at the destination MAC; in_end_of_packet marks the last byte. A byte is
//   taken on any cycle with in_valid high and in_stall low, so a frame moves
//   at one byte per cycle.
//   Output channel (out_*): one transaction per frame, issued for its last
//   byte: drop verdict, class (none / IDR / non-IDR) and the running IDR and
//   non-IDR totals after this frame.
//   Config channel (cfg_*): cfg_ready is always high; index 0 dest_address,
//   1 UDP destination port, 2 drop_period. Other indexes are ignored.
//   Write only idle.
// Path: a verdict goes through the queue write, then the output register,
//   before it shows on out_valid.
// Throughput: one byte per cycle without in_stall; back-to-back single-byte
//   frames give one result per cycle as long as the receiver does not stall.
// Stall: the output register holds its transaction while out_stall is high;
//   verdicts back up in a 4-entry queue, and in_stall rises only when that
//   queue is full. Bytes other than last bytes could pass but are held too.
// Reset: synchronous, active low; registers return to their reset values,
//   counters, phase and queue clear, and a new frame is expected.
`timescale 1ns / 1ps
`default_nettype none

module rtp_h264_idr_packet_dropper (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // byte input
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_packet_byte,
  input  wire logic                         in_end_of_packet,
  // verdict output
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_drop,
  output logic [1:0]                        out_frame_class,
  output logic [rtpidr_pkg::TOTAL_BITS-1:0] out_idr_total,
  output logic [rtpidr_pkg::TOTAL_BITS-1:0] out_non_idr_total,
  // register writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [31:0]                  cfg_data
);
  import rtpidr_pkg::*;

  cfg_t         cfg_r;
  logic         byte_accept;
  frame_class_t verdict_class;
  logic         verdict_push;
  logic         queue_full, queue_empty, queue_pop;
  frame_class_t queue_class;
  frame_class_t out_class;

  // Register file: always ready, writes land at the handshake edge.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_address <= DEST_ADDRESS_RESET;
      cfg_r.udp_port <= UDP_PORT_RESET;
      cfg_r.drop_period <= DROP_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEST_ADDRESS: cfg_r.dest_address <= cfg_data;
        CFG_UDP_PORT:     cfg_r.udp_port <= cfg_data[15:0];
        CFG_DROP_PERIOD:  cfg_r.drop_period <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  // Only the queue can hold up the byte stream.
  assign in_stall = queue_full;
  assign byte_accept = in_valid && !in_stall;

  rtpidr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .byte_accept   (byte_accept),
    .packet_byte   (in_packet_byte),
    .end_of_packet (in_end_of_packet),
    .verdict_class (verdict_class),
    .verdict_push  (verdict_push)
  );

  rtpidr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (verdict_push),
    .push_class (verdict_class),
    .full       (queue_full),
    .pop        (queue_pop),
    .pop_class  (queue_class),
    .empty      (queue_empty)
  );

  rtpidr_counter u_counter (
    .clk               (clk),
    .rst_n             (rst_n),
    .drop_period       (cfg_r.drop_period),
    .queue_empty       (queue_empty),
    .queue_class       (queue_class),
    .queue_pop         (queue_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drop          (out_drop),
    .out_frame_class   (out_class),
    .out_idr_total     (out_idr_total),
    .out_non_idr_total (out_non_idr_total)
  );

  assign out_frame_class = out_class;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for rtp_h264_idr_packet_dropper: byte-level frame stimulus,
// random flow control on both channels, register reprogramming between phases.
// Depends on rtpidr_pkg and the dropper RTL only.
`timescale 1ns / 1ps

module tb;
  import rtpidr_pkg::*;

  // Header fields the dropper keys on.
  localparam logic [7:0] ETH_IPV4_HI = 8'h08;
  localparam logic [7:0] ETH_IPV4_LO = 8'h00;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [1:0] RTP_VERSION = 2'd2;
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_FU_A = 5'd28;
  localparam logic [6:0] POS_SATURATED = 7'd127;
  localparam int MIN_IHL = 5;

  // Ways a generated RTP frame can be broken.
  typedef enum int {
    FLAW_NONE,
    FLAW_ETHTYPE_HI,
    FLAW_ETHTYPE_LO,
    FLAW_LOW_IHL,
    FLAW_PROTO,
    FLAW_ADDR,
    FLAW_PORT,
    FLAW_VERSION,
    FLAW_SHORT_PAYLOAD
  } flaw_t;

  typedef struct packed {
    logic         drop;
    frame_class_t cls;
    logic [31:0]  idr_total;
    logic [31:0]  non_idr_total;
  } verdict_t;

  // Frame parser / IDR thinning predictor plus the queue of verdicts it owes.
  class verdict_board;
    logic [31:0]           dest_addr;
    logic [15:0]           udp_port;
    logic [7:0]            period;
    logic [6:0]            byte_pos;
    logic [3:0]            hdr_words;
    bit                    matching;
    logic [7:0]            pay0;
    logic [7:0]            pay1;
    logic [COUNT_BITS-1:0] idr_cnt;
    logic [COUNT_BITS-1:0] non_cnt;
    logic [7:0]            idr_phase;
    verdict_t              due[$];
    int                    errors;
    int                    frames;
    int                    idr_seen;
    int                    non_seen;
    int                    dropped;

    function new();
      dest_addr = DEST_ADDRESS_RESET;
      udp_port = UDP_PORT_RESET;
      period = DROP_PERIOD_RESET;
      idr_cnt = '0;
      non_cnt = '0;
      idr_phase = '0;
      errors = 0;
      frames = 0;
      idr_seen = 0;
      non_seen = 0;
      dropped = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos = '0;
      hdr_words = '0;
      matching = 1'b1;
      pay0 = '0;
      pay1 = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_DEST_ADDRESS: dest_addr = val;
        CFG_UDP_PORT: udp_port = val[15:0];
        CFG_DROP_PERIOD: period = val[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    // One accepted byte; queues a verdict when it closes the frame.
    function void note_byte(logic [7:0] b, logic last);
      int         p;
      int         udp;
      logic [7:0] want;
      bit         test;
      logic [4:0] nal;
      verdict_t   v;
      p = byte_pos;
      udp = 14 + int'(hdr_words) * 4;
      want = '0;
      test = 1'b1;
      if (p == 12) want = ETH_IPV4_HI;
      else if (p == 13) want = ETH_IPV4_LO;
      else if (p == 14) begin
        hdr_words = b[3:0];
        if (b[3:0] < MIN_IHL) matching = 1'b0;
        test = 1'b0;
      end else if (p == 23) want = PROTO_UDP;
      else if (p >= 30 && p <= 33) want = dest_addr[(33 - p) * 8 +: 8];
      else if (p == udp + 2) want = udp_port[15:8];
      else if (p == udp + 3) want = udp_port[7:0];
      else if (p == udp + 8) begin
        if (b[7:6] != RTP_VERSION) matching = 1'b0;
        test = 1'b0;
      end else if (p == udp + 20) begin
        pay0 = b;
        test = 1'b0;
      end else if (p == udp + 21) begin
        pay1 = b;
        test = 1'b0;
      end else test = 1'b0;
      if (test && b != want) matching = 1'b0;
      if (byte_pos != POS_SATURATED) byte_pos++;
      if (!last) return;

      v.drop = 1'b0;
      v.cls = CLASS_NONE;
      if (matching && hdr_words >= MIN_IHL && p >= 14 + int'(hdr_words) * 4 + 21) begin
        nal = pay0[4:0];
        if (nal == NAL_FU_A) nal = pay1[4:0];
        if (nal == NAL_IDR) begin
          v.cls = CLASS_IDR;
          idr_cnt++;
          idr_phase++;
          if (idr_phase >= period) begin
            v.drop = 1'b1;
            idr_phase = '0;
          end
        end else if (nal == NAL_NON_IDR) begin
          v.cls = CLASS_NON_IDR;
          non_cnt++;
        end
      end
      v.idr_total = idr_cnt[31:0];
      v.non_idr_total = non_cnt[31:0];
      due.push_back(v);
      frames++;
      if (v.cls == CLASS_IDR) idr_seen++;
      if (v.cls == CLASS_NON_IDR) non_seen++;
      if (v.drop) dropped++;
      clear_frame();
    endfunction

    function void check_verdict(logic drop, logic [1:0] cls, logic [31:0] idr_t,
                                logic [31:0] non_t);
      verdict_t v;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: verdict with nothing pending: drop=%0d class=%0d", $realtime,
                   drop, cls);
        return;
      end
      v = due.pop_front();
      if (drop !== v.drop || cls !== v.cls || idr_t !== v.idr_total ||
          non_t !== v.non_idr_total) begin
        errors++;
        if (errors <= 10)
          $display("%0t: verdict exp drop=%0d class=%0d idr=%0d non_idr=%0d, got %0d %0d %0d %0d",
                   $realtime, v.drop, v.cls, v.idr_total, v.non_idr_total,
                   drop, cls, idr_t, non_t);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packet_byte = '0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_drop;
  logic [1:0]  out_frame_class;
  logic [TOTAL_BITS-1:0] out_idr_total;
  logic [TOTAL_BITS-1:0] out_non_idr_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  verdict_board sb = new();

  // Addressing the generator aims at; follows the programmed registers.
  logic [31:0] net_addr = DEST_ADDRESS_RESET;
  logic [15:0] net_port = UDP_PORT_RESET;
  logic [7:0]  frame_buf[$];

  int gap_pct = 0;     // chance per byte of a sender gap burst
  int stall_pct = 0;   // chance per cycle of a receiver stall burst
  int stall_left = 0;
  int n_bytes = 0;
  int n_writes = 0;
  int n_settings = 1;

  rtp_h264_idr_packet_dropper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_packet_byte   (in_packet_byte),
    .in_end_of_packet (in_end_of_packet),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drop         (out_drop),
    .out_frame_class  (out_frame_class),
    .out_idr_total    (out_idr_total),
    .out_non_idr_total(out_non_idr_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver back-pressure: stall bursts at the phase's rate.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Nothing moves between the falling edge and the next rising edge, so the
  // values seen here are exactly the ones the upcoming edge will act on.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict(out_drop, out_frame_class, out_idr_total, out_non_idr_total);
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #10_000_000;
    $display("rtp_h264_idr_packet_dropper: mismatch");
    $finish;
  end

  function automatic logic [7:0] flip_bit(logic [7:0] v);
    return v ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] nal_byte(int t);
    return {3'($urandom), 5'(t)};
  endfunction

  // Ethernet + IPv4 + UDP + RTP frame aimed at the current address and port,
  // with at most one field broken according to flaw.
  function automatic void build_rtp(int ihl, int t0, int t1, int tail, flaw_t flaw);
    int          opt_bytes;
    int          k;
    logic [1:0]  ver;
    logic [31:0] addr;
    logic [15:0] port;
    frame_buf.delete();
    if (flaw == FLAW_LOW_IHL) ihl = $urandom_range(0, MIN_IHL - 1);
    opt_bytes = (ihl > MIN_IHL) ? (ihl - MIN_IHL) * 4 : 0;
    addr = net_addr;
    port = net_port;
    if (flaw == FLAW_ADDR) begin
      k = $urandom_range(0, 3);
      addr[k * 8 +: 8] = flip_bit(addr[k * 8 +: 8]);
    end
    if (flaw == FLAW_PORT) begin
      k = $urandom_range(0, 1);
      port[k * 8 +: 8] = flip_bit(port[k * 8 +: 8]);
    end

    repeat (12) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(flaw == FLAW_ETHTYPE_HI ? flip_bit(ETH_IPV4_HI) : ETH_IPV4_HI);
    frame_buf.push_back(flaw == FLAW_ETHTYPE_LO ? flip_bit(ETH_IPV4_LO) : ETH_IPV4_LO);
    frame_buf.push_back({4'($urandom), 4'(ihl)});
    repeat (8) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(flaw == FLAW_PROTO ? flip_bit(PROTO_UDP) : PROTO_UDP);
    repeat (6) frame_buf.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) frame_buf.push_back(addr[i * 8 +: 8]);
    repeat (opt_bytes) frame_buf.push_back(8'($urandom));

    // UDP header
    repeat (2) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(port[15:8]);
    frame_buf.push_back(port[7:0]);
    repeat (4) frame_buf.push_back(8'($urandom));

    // RTP header; a broken version is any of the other three codes
    ver = RTP_VERSION;
    if (flaw == FLAW_VERSION) begin
      ver = 2'($urandom_range(0, 2));
      if (ver == RTP_VERSION) ver = 2'd3;
    end
    frame_buf.push_back({ver, 6'($urandom)});
    repeat (11) frame_buf.push_back(8'($urandom));

    frame_buf.push_back(nal_byte(t0));
    if (flaw != FLAW_SHORT_PAYLOAD) begin
      frame_buf.push_back(nal_byte(t1));
      repeat (tail) frame_buf.push_back(8'($urandom));
    end
  endfunction

  // Present one byte, holding it until the dropper takes it.
  task automatic push_byte(input logic [7:0] b, input logic last);
    logic ok;
    int   gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packet_byte <= b;
    in_end_of_packet <= last;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    sb.note_byte(b, last);
    n_bytes++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      push_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic send_rtp(input int ihl, input int t0, input int t1, input int tail,
                          input flaw_t flaw);
    build_rtp(ihl, t0, t1, tail, flaw);
    send_frame();
  endtask

  task automatic send_noise(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    send_frame();
  endtask

  // Park the sender until every owed verdict is out, then let the pipe empty.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need only one assignment per edge.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    sb.set_reg(idx, val);
    n_writes++;
  endtask

  task automatic load_regs(input logic [31:0] addr, input logic [15:0] port,
                           input logic [7:0] period);
    write_reg(CFG_DEST_ADDRESS, addr);
    write_reg(CFG_UDP_PORT, {16'd0, port});
    write_reg(CFG_DROP_PERIOD, {24'd0, period});
    cfg_valid <= 1'b0;
    net_addr = addr;
    net_port = port;
    n_settings++;
  endtask

  // One random frame: mostly well-formed RTP with a random NAL mix, the rest
  // broken headers, truncated frames, noise and runs of one-byte frames.
  task automatic random_frame();
    int    r;
    int    ihl;
    int    t0;
    int    t1;
    int    tail;
    int    keep;
    flaw_t flaw;
    r = $urandom_range(0, 99);
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_IHL + 1, 15) : MIN_IHL;
    tail = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 110) : $urandom_range(0, 6);
    t1 = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t0 = NAL_IDR;
      4, 5, 6: t0 = NAL_NON_IDR;
      7, 8: begin
        t0 = NAL_FU_A;
        case ($urandom_range(0, 2))
          0: t1 = NAL_IDR;
          1: t1 = NAL_NON_IDR;
          default: ;
        endcase
      end
      default: t0 = $urandom_range(0, 31);
    endcase

    if (r < 55) begin
      send_rtp(ihl, t0, t1, tail, FLAW_NONE);
    end else if (r < 68) begin
      flaw = flaw_t'($urandom_range(FLAW_ETHTYPE_HI, FLAW_SHORT_PAYLOAD));
      send_rtp(ihl, t0, t1, tail, flaw);
    end else if (r < 78) begin
      build_rtp(ihl, t0, t1, tail, FLAW_NONE);
      keep = $urandom_range(1, frame_buf.size() - 1);
      frame_buf = frame_buf[0:keep - 1];
      send_frame();
    end else if (r < 88) begin
      send_noise($urandom_range(1, 40));
    end else begin
      repeat ($urandom_range(2, 8)) send_noise(1);
    end
  endtask

  // Directed opening under the reset register values (period 10).
  task automatic directed_frames();
    frame_buf = '{8'hFF};
    send_frame();
    frame_buf = '{8'h00};
    send_frame();
    send_rtp(MIN_IHL, NAL_IDR, 0, 0, FLAW_NONE);
    send_rtp(MIN_IHL, NAL_NON_IDR, 0, 3, FLAW_NONE);
    send_rtp(MIN_IHL, NAL_FU_A, NAL_IDR, 2, FLAW_NONE);
    send_rtp(MIN_IHL, NAL_FU_A, NAL_NON_IDR, 2, FLAW_NONE);
    send_rtp(MIN_IHL, NAL_FU_A, NAL_FU_A, 1, FLAW_NONE);
    // NAL types outside IDR / non-IDR pass uncounted
    send_rtp(MIN_IHL, 0, 0, 1, FLAW_NONE);
    send_rtp(MIN_IHL, 31, 31, 1, FLAW_NONE);
    // each header check broken on its own
    for (int f = FLAW_ETHTYPE_HI; f <= FLAW_SHORT_PAYLOAD; f++)
      send_rtp(MIN_IHL, NAL_IDR, 0, 2, flaw_t'(f));
    // widest IP header, then a frame long enough to saturate the position
    send_rtp(15, NAL_IDR, 0, 0, FLAW_NONE);
    send_rtp(MIN_IHL, NAL_IDR, 0, 75, FLAW_NONE);
    // frame cut off inside the UDP header
    build_rtp(MIN_IHL, NAL_IDR, 0, 0, FLAW_NONE);
    frame_buf = frame_buf[0:39];
    send_frame();
    send_rtp(MIN_IHL, NAL_IDR, 0, 0, FLAW_NONE);
  endtask

  initial begin
    int ph_bytes;
    int ph_frames;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    gap_pct = 8;
    stall_pct = 10;
    directed_frames();

    // Six register settings; the first one drops the period under the IDR
    // phase left by the directed part, later ones hit the field extremes
    // (including a zero period) and the last runs with no gaps or stalls.
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin
          load_regs(32'h0000_0000, 16'h0000, 8'd2);
          gap_pct = 8;
          stall_pct = 10;
        end
        1: begin
          load_regs(32'hFFFF_FFFF, 16'hFFFF, 8'd255);
          gap_pct = 0;
          stall_pct = 0;
        end
        2: begin
          load_regs($urandom, 16'($urandom), 8'd1);
          gap_pct = 20;
          stall_pct = 25;
        end
        3: begin
          load_regs($urandom, 16'($urandom), 8'd0);
          gap_pct = 6;
          stall_pct = 45;
        end
        4: begin
          load_regs($urandom, 16'($urandom), 8'($urandom_range(3, 9)));
          gap_pct = 12;
          stall_pct = 12;
        end
        default: begin
          load_regs(DEST_ADDRESS_RESET, UDP_PORT_RESET, 8'd3);
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase

      ph_bytes = n_bytes;
      ph_frames = 0;
      while (n_bytes - ph_bytes < 60 || ph_frames < 2) begin
        random_frame();
        ph_frames++;
        // sender holds off mid-phase until the output side has caught up
        if (ph_frames == 1) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d frames in %0d bytes: %0d IDR (%0d dropped), %0d non-IDR",
             sb.frames, n_bytes, sb.idr_seen, sb.dropped, sb.non_seen);
    $display("%0d register writes across %0d settings, %0d bad verdicts, %0d still owed",
             n_writes, n_settings, sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rtp_h264_idr_packet_dropper: match");
    end else begin
      $display("rtp_h264_idr_packet_dropper: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rtpidr_pkg.sv
src/rtpidr_parser.sv
src/rtpidr_queue.sv
src/rtpidr_counter.sv
src/rtp_h264_idr_packet_dropper.sv
bench/tb.sv
